### hdl/aidr_pkg.sv
`default_nettype none

package aidr_pkg;

  // Timing constants of the audio interface and audio DMA
  localparam int CYCLES_PER_SAMPLE = 10116;
  localparam int DMA_START_DELAY   = 200;
  localparam int DMA_PERIOD        = 4096;

  // State widths
  localparam int PHASE_W     = 14;
  localparam int AI_TICKS_W  = 46;
  localparam int DMA_TICKS_W = 16;
  localparam int BLOCKS_W    = 15;
  localparam int AI_CTRL_W   = 7;
  localparam int DSP_CTRL_W  = 16;
  localparam int DATA_W      = 32;
  localparam int OFFSET_W    = 6;

  localparam logic [PHASE_W-1:0]     CPS_K       = PHASE_W'(CYCLES_PER_SAMPLE);
  localparam logic [DMA_TICKS_W-1:0] DMA_START_K = DMA_TICKS_W'(DMA_START_DELAY);
  localparam logic [DMA_TICKS_W-1:0] DMA_PERIOD_K = DMA_TICKS_W'(DMA_PERIOD);
  localparam logic [DATA_W-1:0]      BLOCK_BYTES = 32'd32;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register spaces
  localparam logic SPACE_AI  = 1'b0;
  localparam logic SPACE_DSP = 1'b1;

  // Register offsets
  localparam logic [OFFSET_W-1:0] AI_CONTROL      = 6'h00;
  localparam logic [OFFSET_W-1:0] AI_VOLUME       = 6'h04;
  localparam logic [OFFSET_W-1:0] AI_SAMPLE_COUNT = 6'h08;
  localparam logic [OFFSET_W-1:0] AI_TIMING       = 6'h0C;
  localparam logic [OFFSET_W-1:0] DSP_CONTROL     = 6'h0A;
  localparam logic [OFFSET_W-1:0] DMA_SRC_HI      = 6'h30;
  localparam logic [OFFSET_W-1:0] DMA_SRC_LO      = 6'h32;
  localparam logic [OFFSET_W-1:0] DMA_CONTROL     = 6'h36;
  localparam logic [OFFSET_W-1:0] DMA_BLOCKS      = 6'h3A;

  // Control bit positions
  localparam int AI_PLAY_BIT      = 0;
  localparam int AI_MASK_BIT      = 2;
  localparam int AI_FLAG_BIT      = 3;
  localparam int AI_CNT_CLEAR_BIT = 5;
  localparam int DSP_FLAG_BIT     = 3;
  localparam int DSP_MASK_BIT     = 4;
  localparam int DMA_ENABLE_BIT   = 15;

  // Write masks
  localparam logic [AI_CTRL_W-1:0] AI_CTRL_WMASK = 7'h57;
  localparam logic [15:0] SRC_LO_MASK  = 16'hFFE0;
  localparam logic [15:0] SRC_HI_WIDE  = 16'h1FFF;
  localparam logic [15:0] SRC_HI_NARROW = 16'h03FF;

  // Configuration register indexes
  localparam logic CFG_WII_MODE = 1'b0;

  typedef struct packed {
    logic [1:0]          op;
    logic                space;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              ai_interrupt;
    logic              dsp_interrupt;
    logic              fetch_valid;
    logic [DATA_W-1:0] fetch_address;
  } result_t;

endpackage

`default_nettype wire

### hdl/aidr_regs.sv
`default_nettype none

module aidr_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire aidr_pkg::item_t item,
  input  wire logic            wii_mode,
  output aidr_pkg::result_t    result
);
  import aidr_pkg::*;

  logic [AI_CTRL_W-1:0]   ai_ctrl_r, ai_ctrl_nxt;
  logic [15:0]            ai_volume_r, ai_volume_nxt;
  logic [DATA_W-1:0]      count_r, count_nxt;
  logic [DATA_W-1:0]      target_r, target_nxt;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [AI_TICKS_W-1:0]  ai_ticks_r, ai_ticks_nxt;
  logic                   ai_armed_r, ai_armed_nxt;
  logic [DSP_CTRL_W-1:0]  dsp_ctrl_r, dsp_ctrl_nxt;
  logic [DATA_W-1:0]      base_r, base_nxt;
  logic [DATA_W-1:0]      cur_r, cur_nxt;
  logic [15:0]            dma_ctrl_r, dma_ctrl_nxt;
  logic [BLOCKS_W-1:0]    blocks_r, blocks_nxt;
  logic [DMA_TICKS_W-1:0] dma_ticks_r, dma_ticks_nxt;
  logic                   dma_armed_r, dma_armed_nxt;

  logic [15:0]            wdata16;
  logic                   is_write_ai;
  logic                   wr_ctrl, wr_count, wr_timing;
  logic                   arm_play;
  logic [DATA_W-1:0]      arm_count, arm_target, arm_diff, arm_n;
  logic [AI_TICKS_W-1:0]  ai_load;
  logic [DATA_W-1:0]      rd_mux;
  logic [PHASE_W-1:0]     phase_inc;
  logic [AI_TICKS_W-1:0]  ai_dec;
  logic [DMA_TICKS_W-1:0] dma_dec;
  logic [BLOCKS_W-1:0]    blocks_dec;
  logic [15:0]            src_hi_mask;
  logic                   dsp_flag_keep;
  logic                   ai_flag_keep;

  assign wdata16     = item.write_data[15:0];
  assign is_write_ai = (item.op == OP_WRITE) && (item.space == SPACE_AI);
  assign wr_ctrl     = is_write_ai && (item.offset == AI_CONTROL);
  assign wr_count    = is_write_ai && (item.offset == AI_SAMPLE_COUNT);
  assign wr_timing   = is_write_ai && (item.offset == AI_TIMING);

  // Operands of the AI countdown load, as the write leaves them
  assign arm_play   = wr_ctrl ? item.write_data[AI_PLAY_BIT] : ai_ctrl_r[AI_PLAY_BIT];
  assign arm_count  = wr_count ? item.write_data :
                      (wr_ctrl && item.write_data[AI_CNT_CLEAR_BIT]) ? '0 : count_r;
  assign arm_target = wr_timing ? item.write_data : target_r;
  assign arm_diff   = arm_target - arm_count;
  assign arm_n      = (arm_diff == '0) ? DATA_W'(1) : arm_diff;
  assign ai_load    = AI_TICKS_W'(arm_n) * AI_TICKS_W'(CPS_K);

  assign src_hi_mask   = wii_mode ? SRC_HI_WIDE : SRC_HI_NARROW;
  assign phase_inc     = phase_r + PHASE_W'(1);
  assign ai_dec        = (ai_ticks_r != '0) ? ai_ticks_r - AI_TICKS_W'(1) : ai_ticks_r;
  assign dma_dec       = (dma_ticks_r != '0) ? dma_ticks_r - DMA_TICKS_W'(1) : dma_ticks_r;
  assign blocks_dec    = (blocks_r != '0) ? blocks_r - BLOCKS_W'(1) : blocks_r;
  assign dsp_flag_keep = wdata16[DSP_FLAG_BIT] ? 1'b0 : dsp_ctrl_r[DSP_FLAG_BIT];
  assign ai_flag_keep  = item.write_data[AI_FLAG_BIT] ? 1'b0 : ai_ctrl_r[AI_FLAG_BIT];

  // Register read mux
  always_comb begin
    rd_mux = '0;
    if (item.space == SPACE_AI) begin
      case (item.offset)
        AI_CONTROL:      rd_mux = DATA_W'(ai_ctrl_r);
        AI_VOLUME:       rd_mux = DATA_W'(ai_volume_r);
        AI_SAMPLE_COUNT: rd_mux = count_r;
        AI_TIMING:       rd_mux = target_r;
        default:         rd_mux = '0;
      endcase
    end else begin
      case (item.offset)
        DSP_CONTROL: rd_mux = DATA_W'(dsp_ctrl_r);
        DMA_SRC_HI:  rd_mux = DATA_W'(base_r[31:16]);
        DMA_SRC_LO:  rd_mux = DATA_W'(base_r[15:0]);
        DMA_CONTROL: rd_mux = DATA_W'(dma_ctrl_r);
        DMA_BLOCKS:  rd_mux = DATA_W'(blocks_dec);
        default:     rd_mux = '0;
      endcase
    end
  end

  // Next state and result for one beat
  always_comb begin
    ai_ctrl_nxt   = ai_ctrl_r;
    ai_volume_nxt = ai_volume_r;
    count_nxt     = count_r;
    target_nxt    = target_r;
    phase_nxt     = phase_r;
    ai_ticks_nxt  = ai_ticks_r;
    ai_armed_nxt  = ai_armed_r;
    dsp_ctrl_nxt  = dsp_ctrl_r;
    base_nxt      = base_r;
    cur_nxt       = cur_r;
    dma_ctrl_nxt  = dma_ctrl_r;
    blocks_nxt    = blocks_r;
    dma_ticks_nxt = dma_ticks_r;
    dma_armed_nxt = dma_armed_r;
    result        = '0;

    if (accept) begin
      case (item.op)
        OP_TICK: begin
          // Advance phase and sample counter
          if (ai_ctrl_r[AI_PLAY_BIT]) begin
            if (phase_inc >= CPS_K) begin
              phase_nxt = '0;
              count_nxt = count_r + DATA_W'(1);
            end else begin
              phase_nxt = phase_inc;
            end
          end
          // AI countdown
          if (ai_armed_r) begin
            ai_ticks_nxt = ai_dec;
            if (ai_dec == '0) begin
              ai_armed_nxt = 1'b0;
              ai_ctrl_nxt[AI_FLAG_BIT] = 1'b1;
            end
          end
          // DMA countdown and block fetch
          if (dma_armed_r) begin
            dma_ticks_nxt = dma_dec;
            if (dma_dec == '0) begin
              dma_armed_nxt = 1'b0;
              if (dma_ctrl_r[DMA_ENABLE_BIT]) begin
                result.fetch_valid   = 1'b1;
                result.fetch_address = cur_r;
                if (blocks_dec == '0) begin
                  cur_nxt    = base_r;
                  blocks_nxt = dma_ctrl_r[BLOCKS_W-1:0];
                  dsp_ctrl_nxt[DSP_FLAG_BIT] = 1'b1;
                end else begin
                  cur_nxt    = cur_r + BLOCK_BYTES;
                  blocks_nxt = blocks_dec;
                end
                dma_ticks_nxt = DMA_PERIOD_K;
                dma_armed_nxt = 1'b1;
              end
            end
          end
        end
        OP_READ: begin
          result.read_data = rd_mux;
        end
        OP_WRITE: begin
          if (item.space == SPACE_AI) begin
            case (item.offset)
              AI_CONTROL: begin
                ai_ctrl_nxt = item.write_data[AI_CTRL_W-1:0] & AI_CTRL_WMASK;
                ai_ctrl_nxt[AI_FLAG_BIT] = ai_flag_keep;
                count_nxt = arm_count;
                phase_nxt = '0;
              end
              AI_VOLUME: ai_volume_nxt = wdata16;
              AI_SAMPLE_COUNT: begin
                count_nxt = item.write_data;
                phase_nxt = '0;
              end
              AI_TIMING: target_nxt = item.write_data;
              default: ;
            endcase
          end else begin
            case (item.offset)
              DSP_CONTROL: begin
                dsp_ctrl_nxt = wdata16;
                dsp_ctrl_nxt[DSP_FLAG_BIT] = dsp_flag_keep;
              end
              DMA_SRC_HI: base_nxt = {wdata16 & src_hi_mask, base_r[15:0]};
              DMA_SRC_LO: base_nxt = {base_r[31:16], wdata16 & SRC_LO_MASK};
              DMA_CONTROL: begin
                dma_ctrl_nxt = wdata16;
                if (!dma_ctrl_r[DMA_ENABLE_BIT] && wdata16[DMA_ENABLE_BIT]) begin
                  cur_nxt       = base_r;
                  blocks_nxt    = wdata16[BLOCKS_W-1:0];
                  dma_ticks_nxt = DMA_START_K;
                  dma_armed_nxt = 1'b1;
                end
              end
              default: ;
            endcase
          end
          // Rearm or drop the AI countdown
          if ((wr_ctrl && (ai_ctrl_r[AI_PLAY_BIT] || arm_play)) || wr_count || wr_timing) begin
            ai_armed_nxt = arm_play;
            ai_ticks_nxt = arm_play ? ai_load : '0;
          end
        end
        default: ;
      endcase
    end

    result.ai_interrupt  = ai_ctrl_nxt[AI_FLAG_BIT] && ai_ctrl_nxt[AI_MASK_BIT];
    result.dsp_interrupt = dsp_ctrl_nxt[DSP_FLAG_BIT] && dsp_ctrl_nxt[DSP_MASK_BIT];
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ai_ctrl_r   <= '0;
      ai_volume_r <= '0;
      count_r     <= '0;
      target_r    <= '0;
      phase_r     <= '0;
      ai_ticks_r  <= '0;
      ai_armed_r  <= 1'b0;
      dsp_ctrl_r  <= '0;
      base_r      <= '0;
      cur_r       <= '0;
      dma_ctrl_r  <= '0;
      blocks_r    <= '0;
      dma_ticks_r <= '0;
      dma_armed_r <= 1'b0;
    end else begin
      ai_ctrl_r   <= ai_ctrl_nxt;
      ai_volume_r <= ai_volume_nxt;
      count_r     <= count_nxt;
      target_r    <= target_nxt;
      phase_r     <= phase_nxt;
      ai_ticks_r  <= ai_ticks_nxt;
      ai_armed_r  <= ai_armed_nxt;
      dsp_ctrl_r  <= dsp_ctrl_nxt;
      base_r      <= base_nxt;
      cur_r       <= cur_nxt;
      dma_ctrl_r  <= dma_ctrl_nxt;
      blocks_r    <= blocks_nxt;
      dma_ticks_r <= dma_ticks_nxt;
      dma_armed_r <= dma_armed_nxt;
    end
  end

  // An armed countdown never sits at zero
  a_ai_armed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ai_armed_r |-> (ai_ticks_r != '0))
    else $error("AI countdown armed at zero");

  a_dma_armed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    dma_armed_r |-> (dma_ticks_r != '0))
    else $error("DMA countdown armed at zero");

  // Phase stays below one sample period
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r < CPS_K)
    else $error("sample phase out of range");

  // Fetch addresses are block aligned
  a_fetch_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    result.fetch_valid |-> (result.fetch_address[4:0] == 5'd0))
    else $error("unaligned DMA fetch address");

endmodule

`default_nettype wire

### hdl/audio_interface_and_dma_registers.sv
// Each accepted beat's result is registered into the out_ register, or into the skid slot while out is stalled.
// Throughput: one item per cycle while in_ready is high; state is updated in the same cycle the item is accepted.
// An output register plus a one-beat skid slot keep in_ready high while one result waits;
// in_ready drops only when both hold a beat. Reset (synchronous, rst_n low) clears all
// registers and counters and empties both result slots.
`default_nettype none

module audio_interface_and_dma_registers (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic        in_space,
  input  wire logic [5:0]  in_offset,
  input  wire logic [31:0] in_write_data,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic             out_ai_interrupt,
  output logic             out_dsp_interrupt,
  output logic             out_fetch_valid,
  output logic [31:0]      out_fetch_address,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import aidr_pkg::*;

  logic    wii_mode_r;
  logic    cfg_write;
  logic    in_accept;
  logic    out_load;
  item_t   item;
  result_t result;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == CFG_WII_MODE) ? {31'b0, wii_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wii_mode_r <= 1'b0;
    end else if (cfg_write && (paddr[2] == CFG_WII_MODE)) begin
      wii_mode_r <= pwdata[0];
    end
  end

  // Register block
  assign in_ready  = !skid_valid_r;
  assign in_accept = in_valid && in_ready;
  assign item      = '{op: in_op, space: in_space, offset: in_offset,
                       write_data: in_write_data};

  aidr_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (item),
    .wii_mode (wii_mode_r),
    .result   (result)
  );

  // Output register with skid stage: hold a beat in the skid slot while out is stalled
  assign out_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= skid_valid_r ? skid_r : result;
    end else if (in_accept) begin
      skid_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_r.read_data;
  assign out_ai_interrupt  = out_r.ai_interrupt;
  assign out_dsp_interrupt = out_r.dsp_interrupt;
  assign out_fetch_valid   = out_r.fetch_valid;
  assign out_fetch_address = out_r.fetch_address;

  // The skid slot only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full with output empty");

  // An accepted beat always shows up on the output the next cycle or waits in skid
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (out_valid_r && (skid_valid_r || $past(out_load))))
    else $error("accepted beat lost");

  // A stalled output with a full skid slot takes no new beat
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> skid_valid_r)
    else $error("skid slot dropped while stalled");

endmodule

`default_nettype wire
